// ----- hdl/ptds_pkg.sv -----
// ----------------------------------------------------------------------------
// ptds_pkg
// Shared widths, reset values and status codes of the PWM divisor search.
// ----------------------------------------------------------------------------
package ptds_pkg;

  localparam int FREQ_W   = 32;
  localparam int CLOCK_W  = 32;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  // multiplier operand: holds 65537 and also prescaler plus one
  localparam int MULT_W   = 17;
  localparam int PROD_W   = FREQ_W + MULT_W;

  localparam logic [CLOCK_W-1:0]  CLOCK_RESET  = 32'd80000000;
  localparam logic [VALUE_W-1:0]  PERIOD_LIMIT = 16'hFFFF;
  // period limit plus two: the prescaler is clock / (this * frequency)
  localparam logic [MULT_W-1:0]   PSC_SPAN     = {1'b0, PERIOD_LIMIT} + MULT_W'(2);

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_FREQ   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABOVE_CLOCK = 2'd2;

endpackage

// ----- hdl/ptds_div.sv -----
// ----------------------------------------------------------------------------
// ptds_div
// Bit-serial restoring divider: one quotient bit per cycle, quotient held
// in the dividend shift register once done.
// ----------------------------------------------------------------------------
module ptds_div #(
  parameter int DIVIDEND_W = ptds_pkg::CLOCK_W,
  parameter int DIVISOR_W  = ptds_pkg::PROD_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] dq;
  logic [DIVISOR_W-1:0]  dvs;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;
  logic                  last_bit;

  always_comb begin
    trial    = {rem, dq[DIVIDEND_W-1]};
    diff     = {1'b0, trial} - {2'b00, dvs};
    fits     = ~diff[DIVISOR_W+1];
    // remainder stays below the divisor, so it fits the narrower register
    rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  assign last_bit = busy && (cnt == CNT_W'(DIVIDEND_W - 1));
  assign quotient = dq;

  // done pulses once the last quotient bit has been shifted in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      done <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (last_bit) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= {dq[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

// ----- hdl/pwm_timer_divisor_search.sv -----
// ----------------------------------------------------------------------------
// pwm_timer_divisor_search
// Timer prescaler and auto-reload period for a requested PWM frequency.
// ----------------------------------------------------------------------------
// sequence: for a valid frequency, two shift-add multiplies and two bit-serial
//   divides on one shared divider, with a setup step between the passes and a
//   registered output; a zero or too-high frequency goes straight to the
//   output step
// requests: one request at a time, next request taken once the result is
//   registered, even while that result still waits at the output
// reset: synchronous, clears control state and loads the clock register with
//   80 MHz
module pwm_timer_divisor_search (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ptds_pkg::FREQ_W-1:0]    target_frequency,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ptds_pkg::VALUE_W-1:0]   prescaler_value,
  output logic [ptds_pkg::VALUE_W-1:0]   period_value,
  output logic [ptds_pkg::STATUS_W-1:0]  status_code,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptds_pkg::CLOCK_W-1:0]   cfg_data
);

  localparam int MCNT_W = $clog2(ptds_pkg::MULT_W);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_MUL      = 6'b000010,
    ST_DIV_GO   = 6'b000100,
    ST_DIV_WAIT = 6'b001000,
    ST_SETUP    = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_t;

  state_t                          state;
  logic                            second_pass;
  logic [ptds_pkg::CLOCK_W-1:0]    timer_clock;
  logic [ptds_pkg::FREQ_W-1:0]     freq;
  logic [ptds_pkg::PROD_W-1:0]     mcand;
  logic [ptds_pkg::MULT_W-1:0]     mplier;
  logic [ptds_pkg::PROD_W-1:0]     acc;
  logic [MCNT_W-1:0]               mcnt;
  logic [ptds_pkg::VALUE_W-1:0]    psc;
  logic [ptds_pkg::VALUE_W-1:0]    per;
  logic [ptds_pkg::STATUS_W-1:0]   status;

  logic                            in_accept;
  logic                            out_free;
  logic                            div_start;
  logic                            div_done;
  logic [ptds_pkg::CLOCK_W-1:0]    div_quotient;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;
  assign div_start = (state == ST_DIV_GO);

  ptds_div #(
    .DIVIDEND_W (ptds_pkg::CLOCK_W),
    .DIVISOR_W  (ptds_pkg::PROD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (timer_clock),
    .divisor  (acc),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock <= ptds_pkg::CLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timer_clock <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      second_pass <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            second_pass <= 1'b0;
            if (target_frequency == '0 || target_frequency > timer_clock) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mcnt == MCNT_W'(ptds_pkg::MULT_W - 1)) begin
            state <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            state <= second_pass ? ST_FINISH : ST_SETUP;
          end
        end
        ST_SETUP: begin
          second_pass <= 1'b1;
          state       <= ST_MUL;
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath: shift-add multiplier and result registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        freq   <= target_frequency;
        mcand  <= ptds_pkg::PROD_W'(target_frequency);
        mplier <= ptds_pkg::PSC_SPAN;
        acc    <= '0;
        mcnt   <= '0;
        psc    <= '0;
        per    <= '0;
        if (target_frequency == '0) begin
          status <= ptds_pkg::STATUS_ZERO_FREQ;
        end else if (target_frequency > timer_clock) begin
          status <= ptds_pkg::STATUS_ABOVE_CLOCK;
        end else begin
          status <= ptds_pkg::STATUS_OK;
        end
      end
      ST_MUL: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[ptds_pkg::PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[ptds_pkg::MULT_W-1:1]};
        mcnt   <= mcnt + MCNT_W'(1);
      end
      ST_DIV_WAIT: begin
        // quotient of 65536 truncates to zero and wraps to the full period
        if (div_done && second_pass) begin
          per <= div_quotient[ptds_pkg::VALUE_W-1:0] - ptds_pkg::VALUE_W'(1);
        end
      end
      ST_SETUP: begin
        psc    <= div_quotient[ptds_pkg::VALUE_W-1:0];
        mplier <= {1'b0, div_quotient[ptds_pkg::VALUE_W-1:0]} + ptds_pkg::MULT_W'(1);
        mcand  <= ptds_pkg::PROD_W'(freq);
        acc    <= '0;
        mcnt   <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      prescaler_value <= psc;
      period_value    <= per;
      status_code     <= status;
    end
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Regression for the PWM divisor search: drives requested frequencies under
// several timer clock settings and random idling on both sides, predicts the
// prescaler, period and status of each request and checks every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_CLOCK = 83;
  localparam int NUM_CLOCKS      = 7;
  localparam int HOLD_CYCLES     = 500;
  localparam int HOLD_AFTER      = 40;
  localparam int DRAIN_CYCLES    = 120;

  typedef struct packed {
    logic [ptds_pkg::VALUE_W-1:0]  prescaler;
    logic [ptds_pkg::VALUE_W-1:0]  period;
    logic [ptds_pkg::STATUS_W-1:0] status;
  } divisor_t;

  // expected divisors in request order, with its own copy of the clock register
  class divisor_scoreboard;
    divisor_t                       pending[$];
    logic [ptds_pkg::CLOCK_W-1:0]   timer_clock;
    int                             errors;

    function new();
      timer_clock = ptds_pkg::CLOCK_RESET;
      errors      = 0;
    endfunction

    function divisor_t predict_divisor(logic [ptds_pkg::FREQ_W-1:0] freq);
      longint unsigned c;
      longint unsigned f;
      longint unsigned psc;
      divisor_t d;
      c = timer_clock;
      f = freq;
      d = '0;
      if (f == 0) begin
        d.status = ptds_pkg::STATUS_ZERO_FREQ;
      end else if (f > c) begin
        d.status = ptds_pkg::STATUS_ABOVE_CLOCK;
      end else begin
        psc         = c / (64'(ptds_pkg::PSC_SPAN) * f);
        d.prescaler = ptds_pkg::VALUE_W'(psc);
        d.period    = ptds_pkg::VALUE_W'(c / ((psc + 1) * f) - 1);
        d.status    = ptds_pkg::STATUS_OK;
      end
      return d;
    endfunction

    function void note_request(logic [ptds_pkg::FREQ_W-1:0] freq);
      pending.push_back(predict_divisor(freq));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(divisor_t got);
      divisor_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, got psc %0d per %0d status %0d", $time,
                 got.prescaler, got.period, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("prescaler_value", want.prescaler, got.prescaler);
      compare_field("period_value", want.period, got.period);
      compare_field("status_code", want.status, got.status);
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [ptds_pkg::FREQ_W-1:0]   target_frequency = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [ptds_pkg::VALUE_W-1:0]  prescaler_value;
  logic [ptds_pkg::VALUE_W-1:0]  period_value;
  logic [ptds_pkg::STATUS_W-1:0] status_code;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ptds_pkg::CLOCK_W-1:0]  cfg_data = '0;

  divisor_scoreboard board = new();
  int                idle_mode = 0;
  int                results_seen = 0;

  pwm_timer_divisor_search u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .target_frequency (target_frequency),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .prescaler_value  (prescaler_value),
    .period_value     (period_value),
    .status_code      (status_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function int sender_idle_pct();
    case (idle_mode)
      0: return 10;
      1: return 53;
      default: return 0;
    endcase
  endfunction

  function int receiver_stall_pct();
    case (idle_mode)
      0: return 53;
      1: return 10;
      default: return 0;
    endcase
  endfunction

  task automatic send_request(logic [ptds_pkg::FREQ_W-1:0] freq);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    target_frequency <= freq;
    do @(posedge clk); while (in_stall);
    board.note_request(freq);
  endtask

  task automatic write_clock(logic [ptds_pkg::CLOCK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.timer_clock = value;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mix of zero, full-range, near-clock and in-range frequencies
  function automatic logic [ptds_pkg::FREQ_W-1:0] pick_frequency(
      logic [ptds_pkg::CLOCK_W-1:0] c);
    int unsigned r;
    longint unsigned spread;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      return '0;
    end else if (r < 26 || c == 0) begin
      return $urandom;
    end else if (r < 36) begin
      return c + $urandom_range(0, 2) - 1;
    end
    spread = longint'($urandom >> $urandom_range(0, 31));
    return ptds_pkg::FREQ_W'(spread % c + 1);
  endfunction

  task automatic run_directed(int phase);
    case (phase)
      0: begin
        send_request(32'd0);
        send_request(32'd1);
        send_request(32'd2);
        send_request(32'd610);
        send_request(32'd611);
        send_request(32'd1220);
        send_request(32'd1221);
        send_request(32'd20000);
        send_request(32'd40000000);
        send_request(32'd79999999);
        send_request(32'd80000000);
        send_request(32'd80000001);
        send_request(32'h5555_5555);
        send_request(32'hAAAA_AAAA);
        send_request(32'hFFFF_FFFF);
      end
      1: begin
        // largest clock, lowest frequency gives the largest prescaler
        send_request(32'd1);
        send_request(32'hFFFF_FFFE);
        send_request(32'hFFFF_FFFF);
      end
      2: begin
        send_request(32'd1);
        send_request(32'd2);
      end
      3: begin
        // zero clock: any nonzero frequency is above it
        send_request(32'd0);
        send_request(32'd1);
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [ptds_pkg::CLOCK_W-1:0] clock_plan[NUM_CLOCKS];
    int random_done;
    clock_plan[0] = ptds_pkg::CLOCK_RESET;
    clock_plan[1] = 32'hFFFF_FFFF;
    clock_plan[2] = 32'd1;
    clock_plan[3] = 32'd0;
    clock_plan[4] = $urandom;
    clock_plan[5] = 32'd48000000;
    clock_plan[6] = $urandom_range(1, 100000);
    random_done = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed(0);
    drain();
    for (int p = 0; p < NUM_CLOCKS; p++) begin
      write_clock(clock_plan[p]);
      if (p != 0) run_directed(p);
      for (int i = 0; i < ITEMS_PER_CLOCK; i++) begin
        idle_mode = random_done * 3 / (NUM_CLOCKS * ITEMS_PER_CLOCK);
        send_request(pick_frequency(board.timer_clock));
        random_done++;
      end
      drain();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("pwm_timer_divisor_search regression: pass");
    end else begin
      $display("pwm_timer_divisor_search regression: fail");
    end
    $finish;
  end

  // result side: checks accepted results and drives the stall, with one long hold-off
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        board.check_result('{prescaler_value, period_value, status_code});
        results_seen++;
      end
      if (!held && results_seen == HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
      end
    end
  end

  initial begin
    #20ms;
    $display("pwm_timer_divisor_search regression: fail");
    $finish;
  end

endmodule
